[rtl/sh2_integer_execute_macros.svh]
// Assertion macros for the SH-2 integer execute block.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef SH2_INTEGER_EXECUTE_MACROS_SVH
`define SH2_INTEGER_EXECUTE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SH2IE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sh2ie assertion failed");

// Next-cycle implication.
`define SH2IE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sh2ie assertion failed");

`else

`define SH2IE_ASSERT_NOW(label, clk, rst, ante, cons)
`define SH2IE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/sh2ie_pkg.sv]
`default_nettype none

package sh2ie_pkg;

   localparam int OP_W   = 4;
   localparam int IW_W   = 16;
   localparam int DATA_W = 32;
   localparam int IMM_W  = 8;

   // Operation codes carried on the request's op field.
   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 4'd0,
      OP_ADDI   = 4'd1,
      OP_ADDC   = 4'd2,
      OP_ADDV   = 4'd3,
      OP_AND    = 4'd4,
      OP_ANDI   = 4'd5,
      OP_BF     = 4'd6,
      OP_BT     = 4'd7,
      OP_CLRMAC = 4'd8,
      OP_CLRT   = 4'd9
   } op_type;

   localparam logic [DATA_W-1:0] PC_STEP     = 32'd2;
   localparam logic [DATA_W-1:0] BRANCH_BASE = 32'd4;

endpackage

`default_nettype wire

[rtl/sh2_integer_execute.sv]
`default_nettype none
// Channel   | Ports                                  | Direction
// ----------+----------------------------------------+----------
// request   | req_valid/req_ready, op, instr. word   | in
// response  | rsp_valid/rsp_ready, pc, T, reg, MAC   | out
//
// A request passes through a register file read, then execute into the output
// register. One request per clock is taken while responses are not stalled,
// with forwarding at the read port covering register hazards.
// Synchronous active-high reset clears PC, T, the pipeline valids and the
// per-register valid bits, so an unwritten register reads as zero.
// A stalled response holds execute, which in turn holds back new requests.

`include "sh2_integer_execute_macros.svh"

module sh2_integer_execute #(
   parameter int REG_COUNT = 16,
   localparam int REG_AW   = $clog2(REG_COUNT)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [sh2ie_pkg::OP_W-1:0]      req_op,
   input  wire logic [sh2ie_pkg::IW_W-1:0]      req_instruction_word,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [sh2ie_pkg::DATA_W-1:0]         rsp_next_pc,
   output logic                                 rsp_t_bit,
   output logic                                 rsp_reg_written,
   output logic [REG_AW-1:0]                    rsp_reg_index,
   output logic [sh2ie_pkg::DATA_W-1:0]         rsp_reg_value,
   output logic                                 rsp_mac_cleared
);

   localparam int DW = sh2ie_pkg::DATA_W;
   localparam int IW = sh2ie_pkg::IMM_W;

   // General register file. It is a synchronous memory with one write port and
   // two read ports; the valid bits stand in for a reset of its contents.
   logic [DW-1:0]        gpr_mem [REG_COUNT];
   logic [REG_COUNT-1:0] gpr_vld_ff;

   // Architectural state, updated each time execute retires an instruction.
   logic [DW-1:0] pc_ff, pc_in;
   logic          t_ff, t_in;

   // Execute stage (stage 1) holding register.
   logic              s1_vld_ff;
   sh2ie_pkg::op_type s1_op_ff;
   logic [REG_AW-1:0] s1_rn_ff;
   logic [IW-1:0]     s1_imm_ff;

   // Read data and forwarding captured at acceptance.
   logic [DW-1:0] rd_a_ff, rd_b_ff, fwd_data_ff;
   logic          a_vld_ff, b_vld_ff, a_fwd_ff, b_fwd_ff;

   // Output register.
   logic              rsp_vld_ff;
   logic [DW-1:0]     rsp_pc_ff;
   logic              rsp_t_ff;
   logic              rsp_wr_ff;
   logic [REG_AW-1:0] rsp_idx_ff;
   logic [DW-1:0]     rsp_val_ff;
   logic              rsp_mac_ff;

   logic              req_fire, s1_fire;
   logic [REG_AW-1:0] rd_addr_a, rd_addr_b;

   logic              wr_req, wr_en, mac_clr;
   logic [REG_AW-1:0] wr_idx;
   logic [DW-1:0]     wr_data;
   logic [DW-1:0]     op_a, op_b, add_opnd, imm_sext, imm_zext, br_off;
   logic              add_cin;
   logic [DW:0]       sum;

   // Handshake. Execute advances whenever the output register is empty or is
   // being emptied, and a new request enters whenever execute is free or moving.
   assign s1_fire   = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // AND #imm always operates on R0, so its first read port is steered there.
   assign rd_addr_a = (sh2ie_pkg::op_type'(req_op) == sh2ie_pkg::OP_ANDI) ?
                      '0 : req_instruction_word[8 +: REG_AW];
   assign rd_addr_b = req_instruction_word[4 +: REG_AW];

   // Register file read. A write retiring on the same edge bypasses the array.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_a_ff     <= gpr_mem[rd_addr_a];
         rd_b_ff     <= gpr_mem[rd_addr_b];
         a_vld_ff    <= gpr_vld_ff[rd_addr_a];
         b_vld_ff    <= gpr_vld_ff[rd_addr_b];
         a_fwd_ff    <= wr_en && (wr_idx == rd_addr_a);
         b_fwd_ff    <= wr_en && (wr_idx == rd_addr_b);
         fwd_data_ff <= wr_data;
      end
   end

   // Register file write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         gpr_mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_vld_ff <= '0;
      end else if (wr_en) begin
         gpr_vld_ff[wr_idx] <= 1'b1;
      end
   end

   // Stage 1 holding register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff  <= sh2ie_pkg::op_type'(req_op);
         s1_rn_ff  <= req_instruction_word[8 +: REG_AW];
         s1_imm_ff <= req_instruction_word[IW-1:0];
      end
   end

   // Operands: forwarded data wins, then the array, and an unwritten register
   // reads as zero.
   assign op_a = a_fwd_ff ? fwd_data_ff : (a_vld_ff ? rd_a_ff : '0);
   assign op_b = b_fwd_ff ? fwd_data_ff : (b_vld_ff ? rd_b_ff : '0);

   assign imm_sext = {{(DW-IW){s1_imm_ff[IW-1]}}, s1_imm_ff};
   assign imm_zext = {{(DW-IW){1'b0}}, s1_imm_ff};
   assign br_off   = {imm_sext[DW-2:0], 1'b0};

   // One shared 33-bit adder serves ADD, ADD #imm, ADDC and ADDV.
   assign add_opnd = (s1_op_ff == sh2ie_pkg::OP_ADDI) ? imm_sext : op_b;
   assign add_cin  = (s1_op_ff == sh2ie_pkg::OP_ADDC) && t_ff;
   assign sum      = {1'b0, op_a} + {1'b0, add_opnd} + {{DW{1'b0}}, add_cin};

   // Execute. PC and T are read straight from their registers, which only move
   // when execute retires an instruction, so no forwarding is needed for them.
   always_comb begin
      wr_req  = 1'b0;
      wr_idx  = s1_rn_ff;
      wr_data = sum[DW-1:0];
      mac_clr = 1'b0;
      t_in    = t_ff;
      pc_in   = pc_ff + sh2ie_pkg::PC_STEP;
      unique case (s1_op_ff) inside
         sh2ie_pkg::OP_ADD, sh2ie_pkg::OP_ADDI: begin
            wr_req = 1'b1;
         end
         sh2ie_pkg::OP_ADDC: begin
            wr_req = 1'b1;
            t_in   = sum[DW];
         end
         sh2ie_pkg::OP_ADDV: begin
            // Signed overflow: equal operand signs and a different result sign.
            wr_req = 1'b1;
            t_in   = ~(op_a[DW-1] ^ op_b[DW-1]) & (op_a[DW-1] ^ sum[DW-1]);
         end
         sh2ie_pkg::OP_AND: begin
            wr_req  = 1'b1;
            wr_data = op_a & op_b;
         end
         sh2ie_pkg::OP_ANDI: begin
            wr_req  = 1'b1;
            wr_idx  = '0;
            wr_data = op_a & imm_zext;
         end
         sh2ie_pkg::OP_BF: begin
            if (!t_ff) begin
               pc_in = pc_ff + sh2ie_pkg::BRANCH_BASE + br_off;
            end
         end
         sh2ie_pkg::OP_BT: begin
            if (t_ff) begin
               pc_in = pc_ff + sh2ie_pkg::BRANCH_BASE + br_off;
            end
         end
         sh2ie_pkg::OP_CLRMAC: begin
            // MACH and MACL are never read out by this block, so only the
            // clear is reported.
            mac_clr = 1'b1;
         end
         sh2ie_pkg::OP_CLRT: begin
            t_in = 1'b0;
         end
         default: begin
            // Unassigned codes retire as a no-op that only advances PC.
         end
      endcase
   end

   assign wr_en = s1_fire && wr_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         t_ff  <= 1'b0;
      end else if (s1_fire) begin
         pc_ff <= pc_in;
         t_ff  <= t_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_pc_ff  <= pc_in;
         rsp_t_ff   <= t_in;
         rsp_wr_ff  <= wr_req;
         rsp_idx_ff <= wr_req ? wr_idx : '0;
         rsp_val_ff <= wr_req ? wr_data : '0;
         rsp_mac_ff <= mac_clr;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_next_pc     = rsp_pc_ff;
   assign rsp_t_bit       = rsp_t_ff;
   assign rsp_reg_written = rsp_wr_ff;
   assign rsp_reg_index   = rsp_idx_ff;
   assign rsp_reg_value   = rsp_val_ff;
   assign rsp_mac_cleared = rsp_mac_ff;

   // A stalled execute stage keeps its request.
   `SH2IE_ASSERT_NEXT(a_s1_hold, clock, reset, s1_vld_ff && !s1_fire,
                      s1_vld_ff && $stable(s1_op_ff) && $stable(s1_rn_ff))

   // A retired register write marks that entry as written.
   `SH2IE_ASSERT_NEXT(a_wr_marks_valid, clock, reset, wr_en, gpr_vld_ff[$past(wr_idx)])

   // A response without a register write carries a zero index and value.
   `SH2IE_ASSERT_NOW(a_no_write_zero, clock, reset, rsp_vld_ff && !rsp_wr_ff,
                     rsp_idx_ff == '0 && rsp_val_ff == '0)

endmodule

`default_nettype wire

[sim/sh2ie_retire_checker.sv]
`default_nettype none

// Watches both channels of the execute stage, keeps its own copy of the
// architectural state and checks every response against the one it predicts.
module sh2ie_retire_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [3:0]  req_op,
   input  wire logic [15:0] req_instruction_word,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [31:0] rsp_next_pc,
   input  wire logic        rsp_t_bit,
   input  wire logic        rsp_reg_written,
   input  wire logic [3:0]  rsp_reg_index,
   input  wire logic [31:0] rsp_reg_value,
   input  wire logic        rsp_mac_cleared,
   output int               mismatch_count,
   output int               outstanding,
   output int               retired_count,
   output int               taken_branches
);

   typedef struct packed {
      logic [31:0] next_pc;
      logic        t_bit;
      logic        reg_written;
      logic [3:0]  reg_index;
      logic [31:0] reg_value;
      logic        mac_cleared;
   } retire_result_type;

   logic [31:0]       gpr [16];
   logic [31:0]       pc_model;
   logic              t_model;
   logic [31:0]       mach_model;
   logic [31:0]       macl_model;
   retire_result_type expected_retires [$];

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("MISMATCH at response %0d: %s expected %h got %h",
                  retired_count, what, want, got);
      end
   endtask

   // Executes one instruction on the model state and returns its response.
   task automatic retire_instruction(input logic [3:0] op, input logic [15:0] iw,
                                     output retire_result_type res);
      logic [3:0]  rn;
      logic [3:0]  rm;
      logic [7:0]  imm;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] sum;
      logic [32:0] wide;
      logic [31:0] next;
      rn   = iw[11:8];
      rm   = iw[7:4];
      imm  = iw[7:0];
      a    = gpr[rn];
      b    = gpr[rm];
      next = pc_model + sh2ie_pkg::PC_STEP;
      res  = '0;
      case (op)
         sh2ie_pkg::OP_ADD: begin
            res.reg_written = 1'b1; res.reg_index = rn; res.reg_value = a + b;
         end
         sh2ie_pkg::OP_ADDI: begin
            res.reg_written = 1'b1; res.reg_index = rn;
            res.reg_value = a + {{24{imm[7]}}, imm};
         end
         sh2ie_pkg::OP_ADDC: begin
            wide = {1'b0, a} + {1'b0, b} + {32'd0, t_model};
            res.reg_written = 1'b1; res.reg_index = rn; res.reg_value = wide[31:0];
            t_model = wide[32];
         end
         sh2ie_pkg::OP_ADDV: begin
            sum = a + b;
            res.reg_written = 1'b1; res.reg_index = rn; res.reg_value = sum;
            t_model = (a[31] == b[31]) && (sum[31] != a[31]);
         end
         sh2ie_pkg::OP_AND: begin
            res.reg_written = 1'b1; res.reg_index = rn; res.reg_value = a & b;
         end
         sh2ie_pkg::OP_ANDI: begin
            res.reg_written = 1'b1; res.reg_index = 4'd0;
            res.reg_value = gpr[0] & {24'd0, imm};
         end
         sh2ie_pkg::OP_BF, sh2ie_pkg::OP_BT: begin
            if (t_model == (op == sh2ie_pkg::OP_BT)) begin
               next = pc_model + sh2ie_pkg::BRANCH_BASE + {{23{imm[7]}}, imm, 1'b0};
               taken_branches++;
            end
         end
         sh2ie_pkg::OP_CLRMAC: begin
            mach_model = '0; macl_model = '0; res.mac_cleared = 1'b1;
         end
         sh2ie_pkg::OP_CLRT: begin
            t_model = 1'b0;
         end
         default: begin
         end
      endcase
      if (res.reg_written) begin
         gpr[res.reg_index] = res.reg_value;
      end
      pc_model    = next;
      res.next_pc = next;
      res.t_bit   = t_model;
   endtask

   always @(posedge clock) begin : watch_channels
      retire_result_type want;
      retire_result_type pred;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            gpr[i] = '0;
         end
         pc_model   = '0;
         t_model    = 1'b0;
         mach_model = '0;
         macl_model = '0;
         expected_retires.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_retires.size() == 0) begin
               report_mismatch("response with no request outstanding", '0, rsp_next_pc);
            end else begin
               want = expected_retires.pop_front();
               if (rsp_next_pc !== want.next_pc)
                  report_mismatch("next_pc", want.next_pc, rsp_next_pc);
               if (rsp_t_bit !== want.t_bit)
                  report_mismatch("t_bit", 32'(want.t_bit), 32'(rsp_t_bit));
               if (rsp_reg_written !== want.reg_written)
                  report_mismatch("reg_written", 32'(want.reg_written),
                                  32'(rsp_reg_written));
               if (rsp_reg_index !== want.reg_index)
                  report_mismatch("reg_index", 32'(want.reg_index), 32'(rsp_reg_index));
               if (rsp_reg_value !== want.reg_value)
                  report_mismatch("reg_value", want.reg_value, rsp_reg_value);
               if (rsp_mac_cleared !== want.mac_cleared)
                  report_mismatch("mac_cleared", 32'(want.mac_cleared),
                                  32'(rsp_mac_cleared));
               retired_count++;
            end
         end
         if (req_valid && req_ready) begin
            retire_instruction(req_op, req_instruction_word, pred);
            expected_retires.push_back(pred);
         end
      end
      outstanding <= expected_retires.size();
   end

endmodule

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

// Top level of the execute stage bench. It generates the clock and reset,
// drives requests and response back-pressure, and gives the verdict. All
// prediction and comparison live in the retire checker beside the block.
module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_op = '0;
   logic [15:0] req_instruction_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_next_pc;
   logic        rsp_t_bit;
   logic        rsp_reg_written;
   logic [3:0]  rsp_reg_index;
   logic [31:0] rsp_reg_value;
   logic        rsp_mac_cleared;

   int mismatch_count;
   int outstanding;
   int retired_count;
   int taken_branches;

   // Percentages of cycles in which the request side idles and the response
   // side stalls. The stimulus changes them from one phase to the next.
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int requests_sent = 0;
   int directed_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   sh2_integer_execute u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_instruction_word (req_instruction_word),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_next_pc          (rsp_next_pc),
      .rsp_t_bit            (rsp_t_bit),
      .rsp_reg_written      (rsp_reg_written),
      .rsp_reg_index        (rsp_reg_index),
      .rsp_reg_value        (rsp_reg_value),
      .rsp_mac_cleared      (rsp_mac_cleared)
   );

   sh2ie_retire_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_instruction_word (req_instruction_word),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_next_pc          (rsp_next_pc),
      .rsp_t_bit            (rsp_t_bit),
      .rsp_reg_written      (rsp_reg_written),
      .rsp_reg_index        (rsp_reg_index),
      .rsp_reg_value        (rsp_reg_value),
      .rsp_mac_cleared      (rsp_mac_cleared),
      .mismatch_count       (mismatch_count),
      .outstanding          (outstanding),
      .retired_count        (retired_count),
      .taken_branches       (taken_branches)
   );

   // Response back-pressure. A fresh decision is made on every edge, so a
   // stall can land on any stage of the block's pipeline.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Presents one request and returns at the edge where it is accepted. It is
   // always called at a rising edge. While idling, the payload carries junk
   // so that the block is seen to ignore it when valid is low. Each pass
   // through the idle loop assigns each signal once and then waits, so no signal
   // receives two nonblocking assignments in the same time step.
   task automatic send_instruction(input logic [3:0] op, input logic [15:0] iw);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         req_op <= 4'($urandom);
         req_instruction_word <= 16'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_instruction_word <= iw;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   // Random program. Most requests are the ten real operations; a few carry
   // the unused codes, which must behave as a plain PC advance. Half the
   // time the register fields are pulled into R0..R3, so that back-to-back
   // requests depend on each other and the read-port forwarding is used.
   // Repeated adds make the values grow quickly, which brings carries and
   // signed overflows, and with them both outcomes of BF and BT.
   task automatic send_random_program(input int count);
      logic [3:0]  op;
      logic [15:0] iw;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 8) begin
            op = 4'($urandom_range(10, 15));
         end else begin
            op = 4'($urandom_range(0, 9));
         end
         iw = 16'($urandom);
         if ($urandom_range(1, 0) == 1) begin
            iw[11:8] = 4'($urandom_range(0, 3));
            iw[7:4] = 4'($urandom_range(0, 3));
         end
         send_instruction(op, iw);
      end
   endtask

   // The main sequence: reset, a directed opening, then four random phases
   // with different idle and stall mixes, then the drain and the verdict.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening with no idling. Each line notes the state it leaves.
      // The top nibble of the first word is set to show it is ignored.
      send_instruction(sh2ie_pkg::OP_ADDI, 16'h717F);   // R1 = 0x0000007F, largest positive imm
      send_instruction(sh2ie_pkg::OP_ADDI, 16'h0280);   // R2 = 0xFFFFFF80, most negative imm
      send_instruction(sh2ie_pkg::OP_ADD, 16'h0320);    // R3 = 0xFFFFFF80
      send_instruction(sh2ie_pkg::OP_ADDC, 16'h0222);   // R2 = 0xFFFFFF00, carry out sets T
      send_instruction(sh2ie_pkg::OP_BT, 16'h007F);     // taken, largest forward displacement
      send_instruction(sh2ie_pkg::OP_BF, 16'hF080);     // not taken while T is set
      send_instruction(sh2ie_pkg::OP_ADDC, 16'h0420);   // R4 = R2 + carry in, T clear
      send_instruction(sh2ie_pkg::OP_BF, 16'h0080);     // taken, largest backward displacement
      send_instruction(sh2ie_pkg::OP_BT, 16'h0001);     // not taken while T is clear
      send_instruction(sh2ie_pkg::OP_ADDV, 16'h0110);   // R1 = 0xFE, no overflow
      send_instruction(sh2ie_pkg::OP_AND, 16'h0310);    // R3 = 0xFFFFFF80 & 0xFE
      send_instruction(sh2ie_pkg::OP_ADDI, 16'h0080);   // R0 = 0xFFFFFF80
      send_instruction(sh2ie_pkg::OP_ANDI, 16'hFAFF);   // R0 = 0x80, Rn field ignored
      send_instruction(sh2ie_pkg::OP_CLRMAC, 16'hFFFF); // all operand bits ignored
      send_instruction(sh2ie_pkg::OP_ADDC, 16'h0222);   // sets T again
      send_instruction(sh2ie_pkg::OP_CLRT, 16'hFFFF);   // T back to zero
      // Unused codes leave everything but the PC alone, whatever the word.
      for (int code = 10; code < 16; code++) begin
         send_instruction(4'(code), (code % 2 == 0) ? 16'h0000 : 16'hFFFF);
      end
      send_instruction(sh2ie_pkg::OP_ADDI, 16'hFFFF);   // R15 = 0xFFFFFFFF
      send_instruction(sh2ie_pkg::OP_ADDI, 16'h0000);   // R0 + 0, smallest word
      directed_count = requests_sent;

      // Random phases: first no idling at all, then a mostly idle sender,
      // then a mostly stalling receiver, then light idling on both sides.
      send_random_program(356);
      req_idle_pct = 69;
      send_random_program(356);
      req_idle_pct = 0;
      rsp_stall_pct = 69;
      send_random_program(356);
      req_idle_pct = 12;
      rsp_stall_pct = 12;
      send_random_program(356);
      req_valid <= 1'b0;

      // Drain, then give the pipeline room to show any stray
      // response before the verdict. The first edge lets the checker count
      // the last request before the outstanding count is looked at.
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Covered %0d requests (%0d directed): all ten operations, unused codes,",
               requests_sent, directed_count);
      $display("and four idle/stall mixes; %0d responses checked, %0d branches taken.",
               retired_count, taken_branches);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("sh2_integer_execute verification clean");
      end else begin
         $display("sh2_integer_execute verification failed");
      end
      $finish;
   end

   // Watchdog. The slowest correct run needs well under a tenth of this.
   initial begin
      #4000000;
      $display("Timeout with %0d responses still outstanding.", outstanding);
      $display("sh2_integer_execute verification failed");
      $finish;
   end

endmodule

`default_nettype wire
